### rtl/signed_divider_register_unit_macros.svh
// Assertion macros shared by the signed divider register unit RTL.
// Expects clk and rst in the scope where a macro is used.
`ifndef SIGNED_DIVIDER_REGISTER_UNIT_MACROS_SVH
`define SIGNED_DIVIDER_REGISTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDRU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sdru_pkg.sv
// Shared types and constants for the signed divider register unit.
// No dependencies.
package sdru_pkg;

  localparam int WORD_W = 32;
  localparam int DATA_W = 64;
  localparam int STEP_N = DATA_W;
  localparam int CNT_W  = $clog2(STEP_N);

  localparam logic [2:0] TGT_CTRL    = 3'd0;
  localparam logic [2:0] TGT_NUM_LO  = 3'd1;
  localparam logic [2:0] TGT_NUM_HI  = 3'd2;
  localparam logic [2:0] TGT_DEN_LO  = 3'd3;
  localparam logic [2:0] TGT_DEN_HI  = 3'd4;

  localparam logic [1:0] MODE_MASK = 2'b11;
  localparam logic [1:0] MODE_32   = 2'd0;

  localparam logic [DATA_W-1:0] ZDIV_Q32_NEG = 64'hFFFF_FFFF_0000_0001;
  localparam logic [DATA_W-1:0] ZDIV_Q32_POS = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DATA_W-1:0] ZDIV_Q64_NEG = 64'h0000_0000_0000_0001;
  localparam logic [DATA_W-1:0] ZDIV_Q64_POS = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]        mode;
    logic [WORD_W-1:0] write_mask;
    logic [WORD_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient;
    logic signed [DATA_W-1:0] remainder;
    logic                     zero_divisor_flag;
    logic [1:0]               width_readback;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_HOLD
  } state_t;

endpackage

### rtl/sdru_regs.sv
// Operand and control registers with bit-masked writes.
// Depends on sdru_pkg.
module sdru_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr,
  input  sdru_pkg::req_t            req,
  output logic [1:0]                width_mode,
  output logic [sdru_pkg::DATA_W-1:0] numerator,
  output logic [sdru_pkg::DATA_W-1:0] denominator
);

  logic [sdru_pkg::WORD_W-1:0] m;
  logic [sdru_pkg::WORD_W-1:0] v;

  assign m = req.write_mask;
  assign v = req.write_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode  <= '0;
      numerator   <= '0;
      denominator <= '0;
    end else if (wr) begin
      unique case (req.mode)
        sdru_pkg::TGT_CTRL: begin
          width_mode <= (width_mode & ~(m[1:0] & sdru_pkg::MODE_MASK))
                      | (v[1:0] & m[1:0] & sdru_pkg::MODE_MASK);
        end
        sdru_pkg::TGT_NUM_LO: begin
          numerator[31:0] <= (numerator[31:0] & ~m) | (v & m);
        end
        sdru_pkg::TGT_NUM_HI: begin
          numerator[63:32] <= (numerator[63:32] & ~m) | (v & m);
        end
        sdru_pkg::TGT_DEN_LO: begin
          denominator[31:0] <= (denominator[31:0] & ~m) | (v & m);
        end
        sdru_pkg::TGT_DEN_HI: begin
          denominator[63:32] <= (denominator[63:32] & ~m) | (v & m);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/sdru_div_core.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on sdru_pkg.
module sdru_div_core (
  input  logic                              clk,
  input  logic                              rst,
  input  sdru_pkg::div_ctl_t                ctl,
  input  logic [sdru_pkg::DATA_W-1:0]       num,
  input  logic [sdru_pkg::WORD_W-1:0]       den,
  output logic                              done,
  output logic [sdru_pkg::DATA_W-1:0]       quotient,
  output logic [sdru_pkg::DATA_W-1:0]       remainder
);

  logic [sdru_pkg::DATA_W-1:0] dividend;
  logic [sdru_pkg::DATA_W-1:0] dividend_mag;
  logic [sdru_pkg::WORD_W-1:0] divisor_mag;
  logic [sdru_pkg::DATA_W-1:0] orig;
  logic [sdru_pkg::DATA_W-1:0] quo;
  logic [sdru_pkg::WORD_W-1:0] part;
  logic [sdru_pkg::WORD_W-1:0] dvs;
  logic [sdru_pkg::CNT_W-1:0]  cnt;
  logic                        run;
  logic                        fin;
  logic                        neg_n;
  logic                        neg_d;
  logic                        zero_d;
  logic                        wide;
  logic [sdru_pkg::WORD_W:0]   shifted;
  logic [sdru_pkg::WORD_W+1:0] diff;
  logic [sdru_pkg::DATA_W-1:0] rem_mag;

  assign dividend = ctl.wide ? num
                  : {{(sdru_pkg::DATA_W-sdru_pkg::WORD_W){num[sdru_pkg::WORD_W-1]}},
                     num[sdru_pkg::WORD_W-1:0]};
  assign dividend_mag = dividend[sdru_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign divisor_mag  = den[sdru_pkg::WORD_W-1] ? (~den + 1'b1) : den;

  assign shifted = {part, quo[sdru_pkg::DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign rem_mag = {{(sdru_pkg::DATA_W-sdru_pkg::WORD_W){1'b0}}, part};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == sdru_pkg::CNT_W'(sdru_pkg::STEP_N - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      orig   <= dividend;
      quo    <= dividend_mag;
      part   <= '0;
      dvs    <= divisor_mag;
      neg_n  <= dividend[sdru_pkg::DATA_W-1];
      neg_d  <= den[sdru_pkg::WORD_W-1];
      zero_d <= (den == '0);
      wide   <= ctl.wide;
    end else if (run) begin
      if (!diff[sdru_pkg::WORD_W+1]) begin
        part <= diff[sdru_pkg::WORD_W-1:0];
        quo  <= {quo[sdru_pkg::DATA_W-2:0], 1'b1};
      end else begin
        part <= shifted[sdru_pkg::WORD_W-1:0];
        quo  <= {quo[sdru_pkg::DATA_W-2:0], 1'b0};
      end
    end
    if (fin) begin
      priority if (zero_d) begin
        remainder <= orig;
        if (wide) begin
          quotient <= neg_n ? sdru_pkg::ZDIV_Q64_NEG : sdru_pkg::ZDIV_Q64_POS;
        end else begin
          quotient <= neg_n ? sdru_pkg::ZDIV_Q32_NEG : sdru_pkg::ZDIV_Q32_POS;
        end
      end else begin
        quotient  <= (neg_n ^ neg_d) ? (~quo + 1'b1) : quo;
        remainder <= neg_n ? (~rem_mag + 1'b1) : rem_mag;
      end
    end
  end

endmodule

### rtl/signed_divider_register_unit.sv
// Top level of the signed divider register unit: handshake, control FSM, result register.
// Depends on sdru_pkg, sdru_regs, sdru_div_core and the assertion macro header.
//
// Each request on the req channel is a masked write to one register: width
// control, numerator low/high word or denominator low/high word. After the
// write the unit divides the numerator (32 bits in mode 0, 64 bits otherwise)
// by the sign-extended low denominator word and returns one response on the
// rsp channel: quotient, remainder, zero-divisor flag and the width mode.
// A request is taken when req_valid is high and req_stall is low; a response
// moves when rsp_valid is high and rsp_stall is low.
// After the request is taken, the operands are loaded into the divider core,
// which retires one quotient bit per cycle, applies the sign fix-up into its
// result registers and hands the result to the output register.
// A new request waits until the division has finished; req_stall is high
// while a division is in flight.
// If rsp_stall holds the previous response, the finished result waits in the
// divider core and req_stall stays high until the result register frees.
// Reset clears the width, numerator and denominator registers to zero,
// returns the controller to idle and drops rsp_valid.
`include "signed_divider_register_unit_macros.svh"

module signed_divider_register_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sdru_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output sdru_pkg::rsp_t  rsp
);

  sdru_pkg::state_t            state;
  sdru_pkg::state_t            state_next;
  sdru_pkg::div_ctl_t          ctl;
  logic                        req_take;
  logic                        out_free;
  logic                        out_load;
  logic                        done;
  logic [1:0]                  width_mode;
  logic [sdru_pkg::DATA_W-1:0] numerator;
  logic [sdru_pkg::DATA_W-1:0] denominator;
  logic [sdru_pkg::DATA_W-1:0] quotient;
  logic [sdru_pkg::DATA_W-1:0] remainder;

  assign req_stall = (state != sdru_pkg::ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  sdru_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .wr          (req_take),
    .req         (req),
    .width_mode  (width_mode),
    .numerator   (numerator),
    .denominator (denominator)
  );

  sdru_div_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .num       (numerator),
    .den       (denominator[sdru_pkg::WORD_W-1:0]),
    .done      (done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.start  = 1'b0;
    ctl.wide   = (width_mode != sdru_pkg::MODE_32);
    out_load   = 1'b0;
    unique case (state)
      sdru_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = sdru_pkg::ST_LOAD;
        end
      end
      sdru_pkg::ST_LOAD: begin
        ctl.start  = 1'b1;
        state_next = sdru_pkg::ST_CALC;
      end
      sdru_pkg::ST_CALC: begin
        if (done) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = sdru_pkg::ST_IDLE;
          end else begin
            state_next = sdru_pkg::ST_HOLD;
          end
        end
      end
      sdru_pkg::ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = sdru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sdru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.quotient          <= quotient;
      rsp.remainder         <= remainder;
      rsp.zero_divisor_flag <= (denominator == '0);
      rsp.width_readback    <= width_mode;
    end
  end

  `SDRU_ASSERT_NEXT(a_take_loads, req_take, state == sdru_pkg::ST_LOAD, "request not loaded")
  `SDRU_ASSERT_NEXT(a_load_calc, state == sdru_pkg::ST_LOAD,
                    state == sdru_pkg::ST_CALC, "no calc after load")
  `SDRU_ASSERT_SAME(a_done_calc, done, state == sdru_pkg::ST_CALC, "divider done outside calc")
  `SDRU_ASSERT_SAME(a_hold_full, state == sdru_pkg::ST_HOLD,
                    rsp_valid, "hold without pending response")

endmodule

### tb/signed_divider_register_unit_test.sv
// Self-checking testbench for signed_divider_register_unit: masked register writes in, one
// quotient/remainder response per write out, checked against an in-bench divide predictor
// or the directed expected values. Depends on sdru_pkg and the signed_divider_register_unit RTL.
module signed_divider_register_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] TGT_SPARE_5 = 3'd5;
  localparam logic [2:0] TGT_SPARE_6 = 3'd6;
  localparam logic [2:0] TGT_SPARE_7 = 3'd7;

  localparam int DIRECTED_N  = 25;
  localparam int RANDOM_N    = 430;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_TAIL  = 80;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] mask;
    logic [31:0] value;
    bit          typed;
    logic [63:0] q;
    logic [63:0] rem;
    logic        z;
    logic [1:0]  w;
  } write_row_t;

  // typed rows carry the expected response; the others use the predictor
  write_row_t directed_rows [DIRECTED_N] = '{
    '{TGT_SPARE_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      64'h0000_0000_FFFF_FFFF, 64'h0, 1'b1, 2'd0},
    '{sdru_pkg::TGT_NUM_LO,  32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
      64'hFFFF_FFFF_0000_0001, 64'hFFFF_FFFF_8000_0000, 1'b1, 2'd0},
    '{sdru_pkg::TGT_DEN_LO,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      64'h0000_0000_8000_0000, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_DEN_LO,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_DEN_HI,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
      64'hFFFF_FFFF_0000_0001, 64'hFFFF_FFFF_8000_0000, 1'b0, 2'd0},
    '{sdru_pkg::TGT_CTRL,    32'h0000_0003, 32'h0000_0001, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_8000_0000, 1'b0, 2'd1},
    '{sdru_pkg::TGT_NUM_HI,  32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_NUM_LO,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
      64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b0, 2'd1},
    '{sdru_pkg::TGT_DEN_LO,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      64'h8000_0000_0000_0000, 64'h0, 1'b0, 2'd1},
    '{sdru_pkg::TGT_CTRL,    32'h0000_0003, 32'h0000_0002, 1'b1,
      64'h8000_0000_0000_0000, 64'h0, 1'b0, 2'd2},
    '{sdru_pkg::TGT_CTRL,    32'h0000_0000, 32'h0000_0003, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_CTRL,    32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_CTRL,    32'h0000_0001, 32'h0000_0001, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_NUM_HI,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_NUM_LO,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_DEN_LO,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_DEN_LO,  32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_NUM_LO,  32'h00FF_00FF, 32'hDEAD_BEEF, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_DEN_HI,  32'hF0F0_F0F0, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{TGT_SPARE_6, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{TGT_SPARE_7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_CTRL,    32'h0000_0003, 32'h0000_0000, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_DEN_LO,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_DEN_HI,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0},
    '{sdru_pkg::TGT_NUM_HI,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0, 1'b0, 2'd0}
  };

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  sdru_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  sdru_pkg::rsp_t rsp;

  logic [1:0]  width_reg;
  logic [63:0] numer_reg;
  logic [63:0] denom_reg;

  sdru_pkg::rsp_t pending_results [$];
  bit             cur_typed;
  sdru_pkg::rsp_t cur_exp;

  int writes_sent;
  int results_seen;
  int spare_writes;
  int zero_div_hits;
  int overflow_hits;
  int mismatches;
  int idle_cycles;

  signed_divider_register_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sdru_pkg::rsp_t divide_after_write(sdru_pkg::req_t w);
    sdru_pkg::rsp_t res;
    longint n;
    longint d;
    logic [31:0] m;
    logic [31:0] v;
    m = w.write_mask;
    v = w.write_value;
    case (w.mode)
      sdru_pkg::TGT_CTRL:   width_reg = (width_reg & ~m[1:0]) | (v[1:0] & m[1:0]);
      sdru_pkg::TGT_NUM_LO: numer_reg[31:0]  = (numer_reg[31:0]  & ~m) | (v & m);
      sdru_pkg::TGT_NUM_HI: numer_reg[63:32] = (numer_reg[63:32] & ~m) | (v & m);
      sdru_pkg::TGT_DEN_LO: denom_reg[31:0]  = (denom_reg[31:0]  & ~m) | (v & m);
      sdru_pkg::TGT_DEN_HI: denom_reg[63:32] = (denom_reg[63:32] & ~m) | (v & m);
      default:              spare_writes++;
    endcase
    d = longint'(signed'(denom_reg[31:0]));
    res.zero_divisor_flag = (denom_reg == 64'h0);
    res.width_readback = width_reg;
    if (d == 0) zero_div_hits++;
    if (width_reg == sdru_pkg::MODE_32) begin
      n = longint'(signed'(numer_reg[31:0]));
      if (numer_reg[31:0] == 32'h8000_0000 && d == -1) begin
        overflow_hits++;
        res.quotient  = 64'h0000_0000_8000_0000;
        res.remainder = 64'h0;
      end else if (d != 0) begin
        res.quotient  = n / d;
        res.remainder = n % d;
      end else begin
        res.quotient  = (n < 0) ? sdru_pkg::ZDIV_Q32_NEG : sdru_pkg::ZDIV_Q32_POS;
        res.remainder = n;
      end
    end else begin
      n = longint'(numer_reg);
      if (numer_reg == 64'h8000_0000_0000_0000 && d == -1) begin
        overflow_hits++;
        res.quotient  = numer_reg;
        res.remainder = 64'h0;
      end else if (d != 0) begin
        res.quotient  = n / d;
        res.remainder = n % d;
      end else begin
        res.quotient  = (n < 0) ? sdru_pkg::ZDIV_Q64_NEG : sdru_pkg::ZDIV_Q64_POS;
        res.remainder = numer_reg;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch_channels
    sdru_pkg::rsp_t predicted;
    sdru_pkg::rsp_t want;
    bit             moved;
    moved = 1'b0;
    if (rst) begin
      width_reg = 2'd0;
      numer_reg = 64'h0;
      denom_reg = 64'h0;
    end else begin
      if (req_valid && !req_stall) begin
        predicted = divide_after_write(req);
        pending_results.push_back(cur_typed ? cur_exp : predicted);
        writes_sent++;
        moved = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("response with no request outstanding: q=%h r=%h", rsp.quotient, rsp.remainder);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.quotient !== want.quotient) begin
            $error("quotient: expected %h, got %h", want.quotient, rsp.quotient);
            mismatches++;
          end
          if (rsp.remainder !== want.remainder) begin
            $error("remainder: expected %h, got %h", want.remainder, rsp.remainder);
            mismatches++;
          end
          if (rsp.zero_divisor_flag !== want.zero_divisor_flag) begin
            $error("zero_divisor_flag: expected %b, got %b",
                   want.zero_divisor_flag, rsp.zero_divisor_flag);
            mismatches++;
          end
          if (rsp.width_readback !== want.width_readback) begin
            $error("width_readback: expected %0d, got %0d",
                   want.width_readback, rsp.width_readback);
            mismatches++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : rsp_backpressure
    int kind;
    int span;
    rsp_stall = 1'b0;
    forever begin
      kind = $urandom_range(0, 2);
      span = (kind == 2) ? $urandom_range(1, 120) : $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (kind)
          0:       rsp_stall = 1'b0;
          1:       rsp_stall = 1'($urandom_range(0, 1));
          default: rsp_stall = 1'b1;
        endcase
      end
    end
  end

  initial begin : drive_requests
    int          burst_left;
    int          gap;
    logic [2:0]  tgt;
    logic [31:0] msk;
    logic [31:0] val;
    logic [3:0]  lanes;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cur_typed = 1'b0;
    cur_exp = '0;
    writes_sent = 0;
    results_seen = 0;
    spare_writes = 0;
    zero_div_hits = 0;
    overflow_hits = 0;
    mismatches = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    burst_left = 0;
    for (int i = 0; i < DIRECTED_N + RANDOM_N; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        if (gap > 0) begin
          req_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      if (i < DIRECTED_N) begin
        req = '{mode: directed_rows[i].mode, write_mask: directed_rows[i].mask,
                write_value: directed_rows[i].value};
        cur_typed = directed_rows[i].typed;
        cur_exp = '{quotient: directed_rows[i].q, remainder: directed_rows[i].rem,
                    zero_divisor_flag: directed_rows[i].z,
                    width_readback: directed_rows[i].w};
      end else begin
        tgt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        lanes = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
          0, 1, 2: msk = 32'hFFFF_FFFF;
          3:       msk = 32'h0;
          4, 5:    msk = {{8{lanes[3]}}, {8{lanes[2]}}, {8{lanes[1]}}, {8{lanes[0]}}};
          default: msk = $urandom;
        endcase
        case ($urandom_range(0, 11))
          0:       val = 32'h0;
          1:       val = 32'h1;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h8000_0000;
          4:       val = 32'h7FFF_FFFF;
          default: val = $urandom;
        endcase
        req = '{mode: tgt, write_mask: msk, write_value: val};
        cur_typed = 1'b0;
      end
      req_valid = 1'b1;
      @(posedge clk);
      while (req_stall) @(posedge clk);
      @(negedge clk);
    end
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("%0d writes (%0d to unused targets), %0d responses checked",
             writes_sent, spare_writes, results_seen);
    $display("%0d zero-divisor and %0d overflow divides hit, %0d mismatches",
             zero_div_hits, overflow_hits, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
